// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of the segment register builder.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGRB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment register builder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SGRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment register builder check failed");

`endif

// ----- rtl/sgrb_pkg.sv -----
// Package of the segment register builder: constants, command and status types.
// Depends on nothing; used by sgrb_ctrl, sgrb_dpath and the top level.
`default_nettype none

package sgrb_pkg;

    localparam logic [6:0]  USER_AREA_CLICKS = 7'd16;
    localparam logic [10:0] PAGE_CLICKS      = 11'd128;
    localparam logic [6:0]  FULL_LEN         = 7'd127;
    localparam logic [7:0]  ACC_RO           = 8'd2;
    localparam logic [7:0]  ACC_RW           = 8'd6;
    localparam logic [7:0]  ACC_ED           = 8'd8;
    localparam int unsigned ACC_WO_BIT       = 2;
    localparam logic [4:0]  MAX_PAGES        = 5'd8;
    localparam logic [4:0]  NREGS            = 5'd16;
    localparam logic [3:0]  LAST_SMALL_IDX   = 4'd7;
    localparam logic [3:0]  LAST_FULL_IDX    = 4'd15;

    localparam logic [15:0] DESC_FULL_RO = {1'b0, FULL_LEN, ACC_RO};
    localparam logic [15:0] DESC_FULL_RW = {1'b0, FULL_LEN, ACC_RW};

    // configuration register indexes
    localparam logic CFG_SMALL_CPU_MODEL = 1'b0;
    localparam logic CFG_MEMORY_LIMIT    = 1'b1;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CHECK,
        CMD_TEXT_STEP,
        CMD_TEXT_END,
        CMD_DATA_STEP,
        CMD_DATA_END,
        CMD_STACK_STEP,
        CMD_EMIT,
        CMD_FAIL
    } t_cmd;

    typedef struct packed {
        logic bad;        // request fails a check
        logic rem_zero;   // no clicks left in the current segment
        logic k_zero;     // no register left below the stack
        logic out_free;   // output register can take a word
        logic emit_last;  // next emitted word closes the request
    } t_status;

    // pages of 128 clicks needed for n clicks
    function automatic logic [4:0] pages_for(input logic [10:0] n);
        logic [11:0] sum;
        sum = {1'b0, n} + 12'd127;
        return sum[11:7];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sgrb_ctrl.sv -----
// Controller of the segment register builder: one-hot sequencer over the phases.
// Depends on sgrb_pkg (command and status types).
`default_nettype none

module sgrb_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire sgrb_pkg::t_status i_status,
    output sgrb_pkg::t_cmd        o_cmd,
    output logic                  o_in_stall
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_TEXT  = 7'b0000100,
        S_DATA  = 7'b0001000,
        S_STACK = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_FAIL  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = sgrb_pkg::CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = sgrb_pkg::CMD_LOAD;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd   = sgrb_pkg::CMD_CHECK;
                n_state = i_status.bad ? S_FAIL : S_TEXT;
            end
            S_TEXT: begin
                if (i_status.rem_zero) begin
                    o_cmd   = sgrb_pkg::CMD_TEXT_END;
                    n_state = S_DATA;
                end else begin
                    o_cmd = sgrb_pkg::CMD_TEXT_STEP;
                end
            end
            S_DATA: begin
                if (i_status.rem_zero) begin
                    o_cmd   = sgrb_pkg::CMD_DATA_END;
                    n_state = S_STACK;
                end else begin
                    o_cmd = sgrb_pkg::CMD_DATA_STEP;
                end
            end
            S_STACK: begin
                if (i_status.rem_zero || i_status.k_zero) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd = sgrb_pkg::CMD_STACK_STEP;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd = sgrb_pkg::CMD_EMIT;
                    if (i_status.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FAIL: begin
                if (i_status.out_free) begin
                    o_cmd   = sgrb_pkg::CMD_FAIL;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/sgrb_dpath.sv -----
// Datapath of the segment register builder: request latch, size checks, page
// table, layout counters, relocation and output register. Depends on sgrb_pkg.
`default_nettype none

module sgrb_dpath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sgrb_pkg::t_cmd i_cmd,
    output sgrb_pkg::t_status  o_status,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_index,
    input  wire logic [11:0]   i_cfg_data,
    input  wire logic [10:0]   i_text_clicks,
    input  wire logic [10:0]   i_data_clicks,
    input  wire logic [10:0]   i_stack_clicks,
    input  wire logic          i_split_spaces,
    input  wire logic [11:0]   i_proc_base,
    input  wire logic          i_has_shared_text,
    input  wire logic [11:0]   i_text_base,
    input  wire logic          i_out_stall,
    output logic               o_out_valid,
    output logic [3:0]         o_reg_index,
    output logic [15:0]        o_page_address,
    output logic [15:0]        o_page_descriptor,
    output logic               o_failed,
    output logic               o_last
);

    // configuration
    logic        r_small;
    logic [11:0] r_mem_limit;

    // latched request
    logic [10:0] r_nt, r_nd, r_ns;
    logic        r_sep, r_shared;
    logic [11:0] r_pbase, r_tbase;

    // layout counters
    logic [10:0] r_rem;
    logic [15:0] r_addr;
    logic [4:0]  r_k;
    logic [3:0]  r_idx;

    // page table
    logic [15:0] r_tab_addr [16];
    logic [15:0] r_tab_desc [16];
    logic [15:0] r_tab_vld;

    // output register
    logic        r_out_valid;
    logic [3:0]  r_reg_index;
    logic [15:0] r_page_address;
    logic [15:0] r_page_descriptor;
    logic        r_failed;
    logic        r_last;

    logic [4:0]  pt, pd, ps;
    logic [6:0]  pages_all;
    logic [5:0]  pages_ds;
    logic [12:0] size_sum;
    logic        bad;
    logic        rem_full;
    logic [4:0]  k_dec;
    logic        wr_en;
    logic [3:0]  wr_idx;
    logic [15:0] wr_addr;
    logic [15:0] wr_desc;
    logic [3:0]  rd_idx;
    logic [15:0] rd_addr;
    logic [15:0] rd_desc;
    logic [11:0] rel_base;
    logic        emit_last;

    // request checks: page counts, separate I/D on the small model, total size
    always_comb begin
        pt        = sgrb_pkg::pages_for(r_nt);
        pd        = sgrb_pkg::pages_for(r_nd);
        ps        = sgrb_pkg::pages_for(r_ns);
        pages_ds  = 6'(pd) + 6'(ps);
        pages_all = 7'(pt) + 7'(pd) + 7'(ps);
        size_sum  = 13'(r_nt) + 13'(r_nd) + 13'(r_ns) + 13'(sgrb_pkg::USER_AREA_CLICKS);
        if (r_sep) begin
            bad = r_small || (pt > sgrb_pkg::MAX_PAGES) ||
                  (pages_ds > 6'(sgrb_pkg::MAX_PAGES));
        end else begin
            bad = pages_all > 7'(sgrb_pkg::MAX_PAGES);
        end
        if (size_sum > 13'(r_mem_limit)) begin
            bad = 1'b1;
        end
    end

    assign rem_full = (r_rem[10:7] != 4'd0);
    assign k_dec    = r_k - 5'd1;

    // page table write port
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = r_k[3:0];
        wr_addr = r_addr;
        wr_desc = sgrb_pkg::DESC_FULL_RO;
        case (i_cmd)
            sgrb_pkg::CMD_TEXT_STEP: begin
                wr_en   = 1'b1;
                wr_desc = rem_full ? sgrb_pkg::DESC_FULL_RO
                                   : {1'b0, 7'(r_rem - 11'd1), sgrb_pkg::ACC_RO};
            end
            sgrb_pkg::CMD_DATA_STEP: begin
                wr_en   = 1'b1;
                wr_desc = rem_full ? sgrb_pkg::DESC_FULL_RW
                                   : {1'b0, 7'(r_rem - 11'd1), sgrb_pkg::ACC_RW};
            end
            sgrb_pkg::CMD_STACK_STEP: begin
                wr_en   = 1'b1;
                wr_idx  = k_dec[3:0];
                wr_addr = r_addr - 16'(sgrb_pkg::PAGE_CLICKS);
                wr_desc = rem_full ? sgrb_pkg::DESC_FULL_RW
                                   : {1'b0, 7'(sgrb_pkg::PAGE_CLICKS - r_rem),
                                      sgrb_pkg::ACC_RW | sgrb_pkg::ACC_ED};
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // shared space: registers 8-15 mirror 0-7
    assign rd_idx   = r_sep ? r_idx : {1'b0, r_idx[2:0]};
    assign rd_addr  = r_tab_vld[rd_idx] ? r_tab_addr[rd_idx] : 16'd0;
    assign rd_desc  = r_tab_vld[rd_idx] ? r_tab_desc[rd_idx] : 16'd0;
    assign rel_base = rd_desc[sgrb_pkg::ACC_WO_BIT] ? r_pbase
                    : (r_shared ? r_tbase : 12'd0);
    assign emit_last = r_small ? (r_idx == sgrb_pkg::LAST_SMALL_IDX)
                               : (r_idx == sgrb_pkg::LAST_FULL_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small     <= 1'b0;
            r_mem_limit <= 12'd4095;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sgrb_pkg::CFG_SMALL_CPU_MODEL: r_small     <= i_cfg_data[0];
                sgrb_pkg::CFG_MEMORY_LIMIT:    r_mem_limit <= i_cfg_data;
                default:                       r_small     <= r_small;
            endcase
        end
    end

    // request latch and layout counters
    always_ff @(posedge i_clk) begin
        case (i_cmd) inside
            sgrb_pkg::CMD_LOAD: begin
                r_nt     <= i_text_clicks;
                r_nd     <= i_data_clicks;
                r_ns     <= i_stack_clicks;
                r_sep    <= i_split_spaces;
                r_pbase  <= i_proc_base;
                r_shared <= i_has_shared_text;
                r_tbase  <= i_text_base;
                r_idx    <= 4'd0;
            end
            sgrb_pkg::CMD_CHECK: begin
                r_rem  <= r_nt;
                r_addr <= 16'd0;
                r_k    <= 5'd0;
            end
            sgrb_pkg::CMD_TEXT_STEP, sgrb_pkg::CMD_DATA_STEP: begin
                r_k <= r_k + 5'd1;
                if (rem_full) begin
                    r_rem  <= r_rem - sgrb_pkg::PAGE_CLICKS;
                    r_addr <= r_addr + 16'(sgrb_pkg::PAGE_CLICKS);
                end else begin
                    r_rem  <= 11'd0;
                    r_addr <= r_addr + 16'(r_rem);
                end
            end
            sgrb_pkg::CMD_TEXT_END: begin
                if (r_sep && (r_k < sgrb_pkg::MAX_PAGES)) begin
                    r_k <= sgrb_pkg::MAX_PAGES;
                end
                r_rem  <= r_nd;
                r_addr <= 16'(sgrb_pkg::USER_AREA_CLICKS);
            end
            sgrb_pkg::CMD_DATA_END: begin
                r_k    <= r_sep ? sgrb_pkg::NREGS : sgrb_pkg::MAX_PAGES;
                r_rem  <= r_ns;
                r_addr <= r_addr + 16'(r_ns);
            end
            sgrb_pkg::CMD_STACK_STEP: begin
                r_k <= k_dec;
                if (rem_full) begin
                    r_rem  <= r_rem - sgrb_pkg::PAGE_CLICKS;
                    r_addr <= r_addr - 16'(sgrb_pkg::PAGE_CLICKS);
                end else begin
                    r_rem <= 11'd0;
                end
            end
            sgrb_pkg::CMD_EMIT: begin
                r_idx <= r_idx + 4'd1;
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    // page table: valid bits drop on a new request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_vld <= 16'd0;
        end else if (i_cmd == sgrb_pkg::CMD_LOAD) begin
            r_tab_vld <= 16'd0;
        end else if (wr_en) begin
            r_tab_vld[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tab_addr[wr_idx] <= wr_addr;
            r_tab_desc[wr_idx] <= wr_desc;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd == sgrb_pkg::CMD_EMIT) || (i_cmd == sgrb_pkg::CMD_FAIL)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == sgrb_pkg::CMD_EMIT) begin
            r_reg_index       <= r_idx;
            r_page_address    <= rd_addr + 16'(rel_base);
            r_page_descriptor <= rd_desc;
            r_failed          <= 1'b0;
            r_last            <= emit_last;
        end else if (i_cmd == sgrb_pkg::CMD_FAIL) begin
            r_reg_index       <= 4'd0;
            r_page_address    <= 16'd0;
            r_page_descriptor <= 16'd0;
            r_failed          <= 1'b1;
            r_last            <= 1'b1;
        end
    end

    assign o_status.bad       = bad;
    assign o_status.rem_zero  = (r_rem == 11'd0);
    assign o_status.k_zero    = (r_k == 5'd0);
    assign o_status.out_free  = !r_out_valid || !i_out_stall;
    assign o_status.emit_last = emit_last;

    assign o_out_valid       = r_out_valid;
    assign o_reg_index       = r_reg_index;
    assign o_page_address    = r_page_address;
    assign o_page_descriptor = r_page_descriptor;
    assign o_failed          = r_failed;
    assign o_last            = r_last;

endmodule

`default_nettype wire

// ----- rtl/segment_register_builder.sv -----
// Top level of the segment register builder: controller plus datapath.
// Depends on sgrb_pkg, sgrb_ctrl and sgrb_dpath.
//
// The block lays out the user page address/descriptor registers for one
// process. A request word carries text, data and stack sizes in 64-byte
// clicks, the separate I/D flag, the process base and the shared-text base.
// It is first checked (page counts per space, no separate I/D on the small
// CPU model, total size plus the user area against memory_limit); a rejected
// request yields a single word with failed and last set and all other fields
// zero. An accepted request yields 16 words, or 8 on the small model, one per
// page register in ascending order, last set on the final one. The request
// is latched, then checked; the page sequencer then writes one table entry
// per cycle, one per text, data and stack page, and closes each of those
// three phases in turn. The result words then leave through the single
// output register, where output stalls hold them back. One request is in
// work at a time: o_in_stall is high from the accepting edge until the final
// word is loaded into the output register, so the next request can enter
// while that word still waits. Configuration writes are taken at any edge
// with i_cfg_we high and must only be made while the block is idle.
`default_nettype none

module segment_register_builder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [11:0] i_cfg_data,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [10:0] i_text_clicks,
    input  wire logic [10:0] i_data_clicks,
    input  wire logic [10:0] i_stack_clicks,
    input  wire logic        i_split_spaces,
    input  wire logic [11:0] i_proc_base,
    input  wire logic        i_has_shared_text,
    input  wire logic [11:0] i_text_base,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [3:0]       o_reg_index,
    output logic [15:0]      o_page_address,
    output logic [15:0]      o_page_descriptor,
    output logic             o_failed,
    output logic             o_last
);

    sgrb_pkg::t_cmd    cmd;
    sgrb_pkg::t_status status;

    // sequence the phases: latch, check, text, data, stack, emit or fail
    sgrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // hold the request, build the page table, relocate on the way out
    sgrb_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_text_clicks     (i_text_clicks),
        .i_data_clicks     (i_data_clicks),
        .i_stack_clicks    (i_stack_clicks),
        .i_split_spaces    (i_split_spaces),
        .i_proc_base       (i_proc_base),
        .i_has_shared_text (i_has_shared_text),
        .i_text_base       (i_text_base),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_reg_index       (o_reg_index),
        .o_page_address    (o_page_address),
        .o_page_descriptor (o_page_descriptor),
        .o_failed          (o_failed),
        .o_last            (o_last)
    );

endmodule

`default_nettype wire

// ----- rtl/sgrb_checker.sv -----
// Port-level checker for the segment register builder, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module sgrb_port_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [3:0]  o_reg_index,
    input wire logic [15:0] o_page_address,
    input wire logic [15:0] o_page_descriptor,
    input wire logic        o_failed,
    input wire logic        o_last
);

    logic        fail_zeroed;
    logic        last_on_top;
    logic [37:0] out_word;

    assign fail_zeroed = o_last && (o_reg_index == 4'd0) && (o_page_address == 16'd0) &&
                         (o_page_descriptor == 16'd0);
    assign last_on_top = (o_reg_index == 4'd7) || (o_reg_index == 4'd15);
    assign out_word    = {o_reg_index, o_page_address, o_page_descriptor, o_failed, o_last};

    // a rejection is a single zeroed word that closes its request
    `SGRB_ASSERT_IMPL(a_fail_word, i_clk, i_rst_n, o_out_valid && o_failed, fail_zeroed)

    // a good request closes on register 7 or 15
    `SGRB_ASSERT_IMPL(a_last_index, i_clk, i_rst_n, o_out_valid && !o_failed && o_last, last_on_top)

    // one request at a time: stall right after an accept
    `SGRB_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // a stalled result word holds
    `SGRB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(out_word))

endmodule

bind segment_register_builder sgrb_port_checker u_sgrb_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_reg_index       (o_reg_index),
    .o_page_address    (o_page_address),
    .o_page_descriptor (o_page_descriptor),
    .o_failed          (o_failed),
    .o_last            (o_last)
);

`default_nettype wire
